// ===== hdl/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// UV sphere package
// Shared constants, types and helper functions of the UV sphere vertex
// generator: angle constants, the arctangent table and rounding helpers.
// ----------------------------------------------------------------------------
package uvs_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_RADIUS  = 2'd0;
	localparam logic [1:0] REG_STACKS  = 2'd1;
	localparam logic [1:0] REG_SECTORS = 2'd2;

	localparam logic [15:0] RADIUS_RST  = 16'd256;
	localparam logic [7:0]  STACKS_RST  = 8'd16;
	localparam logic [7:0]  SECTORS_RST = 8'd32;

	// Long division: dividend width and quotient bits per stage.
	localparam int DIV_W      = 41;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = (DIV_W + DIV_STEP - 1) / DIV_STEP;

	// Rotation unit in Q2.30.
	localparam int TRIG_ITERATIONS = 16;
	localparam int TRIG_ITER_USED  = (TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS;
	localparam int CORDIC_W        = 32;
	localparam int CORDIC_STEP     = 2;
	localparam int CORDIC_STAGES   = (TRIG_ITER_USED + CORDIC_STEP - 1) / CORDIC_STEP;
	localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 32'sd652032874;

	localparam int POST_STAGES = 4;
	// Input register, divider, angle fold, rotation, products, output register.
	localparam int PIPE_LAT = 1 + DIV_STAGES + 1 + CORDIC_STAGES + POST_STAGES + 1;

	localparam logic [DIV_W-1:0] PI_U     = 41'd3373259426;
	localparam logic [DIV_W-1:0] TWO_PI_U = 41'd6746518852;

	localparam logic signed [34:0] PI_S         = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_S    = 35'sd1686629713;
	localparam logic signed [34:0] THR_HALF_PI_S = 35'sd5059889139;
	localparam logic signed [34:0] TWO_PI_S     = 35'sd6746518852;

	localparam int POS_LIM  = 65535;
	localparam int NORM_LIM = 16384;

	typedef struct packed {
		logic        err;
		logic        neg;
		logic [16:0] tex_s;
		logic [16:0] tex_t;
	} uvs_side_t;

	function automatic logic signed [CORDIC_W-1:0] atan_q30(input int unsigned k);
		logic signed [CORDIC_W-1:0] v;
		v = '0;
		unique case (k)
			0:  v = 32'sd843314857;
			1:  v = 32'sd497837829;
			2:  v = 32'sd263043837;
			3:  v = 32'sd133525159;
			4:  v = 32'sd67021687;
			5:  v = 32'sd33543516;
			6:  v = 32'sd16775851;
			7:  v = 32'sd8388437;
			8:  v = 32'sd4194283;
			9:  v = 32'sd2097149;
			10: v = 32'sd1048576;
			11: v = 32'sd524288;
			12: v = 32'sd262144;
			13: v = 32'sd131072;
			14: v = 32'sd65536;
			15: v = 32'sd32768;
			16: v = 32'sd16384;
			17: v = 32'sd8192;
			18: v = 32'sd4096;
			19: v = 32'sd2048;
			20: v = 32'sd1024;
			21: v = 32'sd512;
			22: v = 32'sd256;
			23: v = 32'sd128;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Round half up by 2^k, then clamp to +-lim.
	function automatic logic signed [17:0] rnd_clamp(input logic signed [67:0] v,
			input int unsigned k, input int lim);
		logic signed [67:0] t;
		logic signed [67:0] l;
		t = (v + (68'sd1 <<< (k - 1))) >>> k;
		l = 68'(lim);
		if (t > l)
			t = l;
		else if (t < -l)
			t = -l;
		return t[17:0];
	endfunction

endpackage

// ===== hdl/uvs_div.sv =====
// ----------------------------------------------------------------------------
// UV sphere divider
// Pipelined restoring long division of a wide dividend by an 8-bit divisor,
// a few quotient bits per stage.
// ----------------------------------------------------------------------------
module uvs_div import uvs_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [7:0]       divisor,
	input  logic [DIV_W-1:0] dividend,
	output logic [DIV_W-1:0] quotient
);

	logic [7:0]       rem_s [DIV_STAGES];
	logic [DIV_W-1:0] dvd_s [DIV_STAGES];
	logic [DIV_W-1:0] quo_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [7:0]       rem_in;
		logic [DIV_W-1:0] dvd_in;
		logic [DIV_W-1:0] quo_in;
		logic [7:0]       rem_nx;
		logic [DIV_W-1:0] dvd_nx;
		logic [DIV_W-1:0] quo_nx;

		if (g == 0) begin : g_first
			assign rem_in = '0;
			assign dvd_in = dividend;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign dvd_in = dvd_s[g-1];
			assign quo_in = quo_s[g-1];
		end

		always_comb begin : p_step
			logic [8:0] r9;
			r9     = '0;
			rem_nx = rem_in;
			dvd_nx = dvd_in;
			quo_nx = quo_in;
			for (int m = 0; m < DIV_STEP; m++) begin
				if (g * DIV_STEP + m < DIV_W) begin
					r9     = {rem_nx, dvd_nx[DIV_W-1]};
					dvd_nx = {dvd_nx[DIV_W-2:0], 1'b0};
					if (r9 >= {1'b0, divisor}) begin
						r9     = r9 - {1'b0, divisor};
						quo_nx = {quo_nx[DIV_W-2:0], 1'b1};
					end else begin
						quo_nx = {quo_nx[DIV_W-2:0], 1'b0};
					end
					rem_nx = r9[7:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_nx;
				dvd_s[g] <= dvd_nx;
				quo_s[g] <= quo_nx;
			end
		end
	end

	assign quotient = quo_s[DIV_STAGES-1];

endmodule

// ===== hdl/uvs_cordic.sv =====
// ----------------------------------------------------------------------------
// UV sphere rotation unit
// Rotation-mode CORDIC in Q2.30, two iterations per pipeline stage, giving
// cosine and sine of an angle in [-pi/2, pi/2].
// ----------------------------------------------------------------------------
module uvs_cordic import uvs_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [CORDIC_W-1:0] angle,
	output logic signed [CORDIC_W-1:0] cos_val,
	output logic signed [CORDIC_W-1:0] sin_val
);

	logic signed [CORDIC_W-1:0] x_s [CORDIC_STAGES];
	logic signed [CORDIC_W-1:0] y_s [CORDIC_STAGES];
	logic signed [CORDIC_W-1:0] z_s [CORDIC_STAGES];

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		logic signed [CORDIC_W-1:0] x_in, y_in, z_in;
		logic signed [CORDIC_W-1:0] x_nx, y_nx, z_nx;

		if (g == 0) begin : g_first
			assign x_in = GAIN_Q30;
			assign y_in = '0;
			assign z_in = angle;
		end else begin : g_next
			assign x_in = x_s[g-1];
			assign y_in = y_s[g-1];
			assign z_in = z_s[g-1];
		end

		always_comb begin : p_iter
			logic signed [CORDIC_W-1:0] dx;
			logic signed [CORDIC_W-1:0] dy;
			dx   = '0;
			dy   = '0;
			x_nx = x_in;
			y_nx = y_in;
			z_nx = z_in;
			for (int m = 0; m < CORDIC_STEP; m++) begin
				if (g * CORDIC_STEP + m < TRIG_ITER_USED) begin
					dx = y_nx >>> (g * CORDIC_STEP + m);
					dy = x_nx >>> (g * CORDIC_STEP + m);
					if (!z_nx[CORDIC_W-1]) begin
						x_nx = x_nx - dx;
						y_nx = y_nx + dy;
						z_nx = z_nx - atan_q30(g * CORDIC_STEP + m);
					end else begin
						x_nx = x_nx + dx;
						y_nx = y_nx - dy;
						z_nx = z_nx + atan_q30(g * CORDIC_STEP + m);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g] <= x_nx;
				y_s[g] <= y_nx;
				z_s[g] <= z_nx;
			end
		end
	end

	assign cos_val = x_s[CORDIC_STAGES-1];
	assign sin_val = y_s[CORDIC_STAGES-1];

endmodule

// ===== hdl/uvs_post.sv =====
// ----------------------------------------------------------------------------
// UV sphere product stages
// Scales the trig terms by the radius and by each other, with half-up
// rounding and clamping, over four register stages.
// ----------------------------------------------------------------------------
module uvs_post import uvs_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic [15:0]                radius,
	input  logic                       neg,
	input  logic signed [CORDIC_W-1:0] cos_e,
	input  logic signed [CORDIC_W-1:0] sin_e,
	input  logic signed [CORDIC_W-1:0] cos_a,
	input  logic signed [CORDIC_W-1:0] sin_a,
	output logic signed [16:0]         px,
	output logic signed [16:0]         py,
	output logic signed [16:0]         pz,
	output logic signed [15:0]         nx,
	output logic signed [15:0]         ny,
	output logic signed [15:0]         nz
);

	logic signed [48:0]         rce_s22, rse_s22;
	logic signed [CORDIC_W-1:0] ce_s22, se_s22, ca_s22, sa_s22;

	logic signed [27:0]         xy_s23;
	logic signed [63:0]         nxp_s23, nyp_s23;
	logic signed [CORDIC_W-1:0] ca_s23, sa_s23;
	logic signed [16:0]         pz_s23;
	logic signed [15:0]         nz_s23;

	logic signed [59:0] pxp_s24, pyp_s24;
	logic signed [16:0] pz_s24;
	logic signed [15:0] nx_s24, ny_s24, nz_s24;

	logic signed [16:0] px_s25, py_s25, pz_s25;
	logic signed [15:0] nx_s25, ny_s25, nz_s25;

	logic signed [16:0] rad_s;
	logic signed [49:0] xy_rnd;
	logic signed [17:0] pz_c, nz_c, nx_c, ny_c, px_c, py_c;

	assign rad_s  = $signed({1'b0, radius});
	assign xy_rnd = (50'(rce_s22) + 50'sd2097152) >>> 22;
	assign pz_c   = rnd_clamp(68'(rse_s22), 30, POS_LIM);
	assign nz_c   = rnd_clamp(68'(se_s22), 16, NORM_LIM);
	assign nx_c   = rnd_clamp(68'(nxp_s23), 46, NORM_LIM);
	assign ny_c   = rnd_clamp(68'(nyp_s23), 46, NORM_LIM);
	assign px_c   = rnd_clamp(68'(pxp_s24), 38, POS_LIM);
	assign py_c   = rnd_clamp(68'(pyp_s24), 38, POS_LIM);

	always_ff @(posedge clk) begin
		if (en) begin
			// Azimuth folded by pi flips both of its trig terms.
			rce_s22 <= rad_s * cos_e;
			rse_s22 <= rad_s * sin_e;
			ce_s22  <= cos_e;
			se_s22  <= sin_e;
			ca_s22  <= neg ? -cos_a : cos_a;
			sa_s22  <= neg ? -sin_a : sin_a;

			xy_s23  <= xy_rnd[27:0];
			nxp_s23 <= ce_s22 * ca_s22;
			nyp_s23 <= ce_s22 * sa_s22;
			ca_s23  <= ca_s22;
			sa_s23  <= sa_s22;
			pz_s23  <= pz_c[16:0];
			nz_s23  <= nz_c[15:0];

			pxp_s24 <= xy_s23 * ca_s23;
			pyp_s24 <= xy_s23 * sa_s23;
			pz_s24  <= pz_s23;
			nx_s24  <= nx_c[15:0];
			ny_s24  <= ny_c[15:0];
			nz_s24  <= nz_s23;

			px_s25 <= px_c[16:0];
			py_s25 <= py_c[16:0];
			pz_s25 <= pz_s24;
			nx_s25 <= nx_s24;
			ny_s25 <= ny_s24;
			nz_s25 <= nz_s24;
		end
	end

	assign px = px_s25;
	assign py = py_s25;
	assign pz = pz_s25;
	assign nx = nx_s25;
	assign ny = ny_s25;
	assign nz = nz_s25;

endmodule

// ===== hdl/uv_sphere_vertex_generator_top.sv =====
// Throughput: one word per cycle while no output stall freezes the pipeline;
// the whole pipeline advances together.
// Depth is set by the 11-stage long divider and the 8-stage rotation unit.
// A stall on a valid output freezes every stage, so nothing is lost or repeated.
// Reset clears all valid bits and loads radius 1.0, 16 stacks, 32 sectors.
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Turns a (stack, sector) grid point into a vertex position, unit normal
// and texture coordinates in fixed point.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_top import uvs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_addr,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         stack_index,
	input  logic [7:0]         sector_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [16:0]        tex_s,
	output logic [16:0]        tex_t,
	output logic               index_error
);

	localparam int ERR_LEN  = 1 + DIV_STAGES;
	localparam int SIDE_LEN = 1 + CORDIC_STAGES + POST_STAGES;

	logic [15:0] radius_q;
	logic [7:0]  stacks_q;
	logic [7:0]  sectors_q;

	logic [PIPE_LAT-1:0] vld_q;
	logic                en;
	logic                acc;

	logic             err_s [ERR_LEN];
	uvs_side_t        side_s [SIDE_LEN];
	logic [DIV_W-1:0] dvd_a_s1, dvd_e_s1, dvd_ts_s1, dvd_tt_s1;
	logic [DIV_W-1:0] quo_a, quo_e, quo_ts, quo_tt;

	logic signed [CORDIC_W-1:0] a_s13, e_s13;
	logic signed [CORDIC_W-1:0] cos_e, sin_e, cos_a, sin_a;
	logic signed [16:0]         px, py, pz;
	logic signed [15:0]         nx, ny, nz;

	logic             in_err;
	logic signed [34:0] a_full, a_fold, e_full;
	logic             a_neg;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			stacks_q  <= STACKS_RST;
			sectors_q <= SECTORS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_RADIUS:  radius_q  <= cfg_data;
				REG_STACKS:  stacks_q  <= cfg_data[7:0];
				REG_SECTORS: sectors_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign en       = !(vld_q[PIPE_LAT-1] && out_stall);
	assign in_stall = !en;
	assign acc      = in_valid && en;
	assign out_valid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], acc};
		end
	end

	assign in_err = (stacks_q == 8'd0) || (sectors_q == 8'd0) ||
		(stack_index > stacks_q) || (sector_index > sectors_q);

	// Stage 1: dividends for both angles and both texture coordinates.
	always_ff @(posedge clk) begin
		if (en) begin
			dvd_a_s1  <= DIV_W'(sector_index) * TWO_PI_U + DIV_W'(sectors_q >> 1);
			dvd_e_s1  <= DIV_W'(stack_index) * PI_U + DIV_W'(stacks_q >> 1);
			dvd_ts_s1 <= (DIV_W'(sector_index) << 16) + DIV_W'(sectors_q >> 1);
			dvd_tt_s1 <= (DIV_W'(stack_index) << 16) + DIV_W'(stacks_q >> 1);
			err_s[0]  <= in_err;
			for (int k = 1; k < ERR_LEN; k++)
				err_s[k] <= err_s[k-1];
		end
	end

	uvs_div u_div_a (.clk, .en, .divisor(sectors_q), .dividend(dvd_a_s1), .quotient(quo_a));
	uvs_div u_div_e (.clk, .en, .divisor(stacks_q), .dividend(dvd_e_s1), .quotient(quo_e));
	uvs_div u_div_ts (.clk, .en, .divisor(sectors_q), .dividend(dvd_ts_s1), .quotient(quo_ts));
	uvs_div u_div_tt (.clk, .en, .divisor(stacks_q), .dividend(dvd_tt_s1), .quotient(quo_tt));

	// Fold the azimuth into [-pi/2, pi/2]: angles above 3pi/2 lose 2pi, and
	// angles in (pi/2, 3pi/2] are handled by subtracting pi and flipping the results later.
	always_comb begin
		a_full = $signed({2'b00, quo_a[32:0]});
		e_full = HALF_PI_S - $signed({3'b000, quo_e[31:0]});
		a_neg  = 1'b0;
		if (a_full > HALF_PI_S && a_full <= THR_HALF_PI_S) begin
			a_fold = a_full - PI_S;
			a_neg  = 1'b1;
		end else if (a_full > THR_HALF_PI_S) begin
			a_fold = a_full - TWO_PI_S;
		end else begin
			a_fold = a_full;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s13           <= a_fold[CORDIC_W-1:0];
			e_s13           <= e_full[CORDIC_W-1:0];
			side_s[0].err   <= err_s[ERR_LEN-1];
			side_s[0].neg   <= a_neg;
			side_s[0].tex_s <= quo_ts[16:0];
			side_s[0].tex_t <= quo_tt[16:0];
			for (int k = 1; k < SIDE_LEN; k++)
				side_s[k] <= side_s[k-1];
		end
	end

	uvs_cordic u_rot_e (.clk, .en, .angle(e_s13), .cos_val(cos_e), .sin_val(sin_e));
	uvs_cordic u_rot_a (.clk, .en, .angle(a_s13), .cos_val(cos_a), .sin_val(sin_a));

	uvs_post u_post (
		.clk,
		.en,
		.radius(radius_q),
		.neg(side_s[CORDIC_STAGES].neg),
		.cos_e,
		.sin_e,
		.cos_a,
		.sin_a,
		.px,
		.py,
		.pz,
		.nx,
		.ny,
		.nz
	);

	// Output register; a bad index answers with zeros and the error flag.
	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s[SIDE_LEN-1].err) begin
				pos_x    <= '0;
				pos_y    <= '0;
				pos_z    <= '0;
				normal_x <= '0;
				normal_y <= '0;
				normal_z <= '0;
				tex_s    <= '0;
				tex_t    <= '0;
			end else begin
				pos_x    <= px;
				pos_y    <= py;
				pos_z    <= pz;
				normal_x <= nx;
				normal_y <= ny;
				normal_z <= nz;
				tex_s    <= side_s[SIDE_LEN-1].tex_s;
				tex_t    <= side_s[SIDE_LEN-1].tex_t;
			end
			index_error <= side_s[SIDE_LEN-1].err;
		end
	end

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> pos_x == 0 && pos_y == 0 && pos_z == 0 &&
		normal_x == 0 && normal_y == 0 && normal_z == 0 && tex_s == 0 && tex_t == 0)
		else $error("index error word carries nonzero fields");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !index_error |-> tex_s <= 17'd65536 && tex_t <= 17'd65536)
		else $error("texture coordinate above one");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
		else $error("normal z outside unit range");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Drives grid points under several radius and count settings with random
// gaps and output stalls. A scoreboard computes each vertex with its own
// rotation-based sine and cosine and checks every output word in order.
// ----------------------------------------------------------------------------
module tb_top import uvs_pkg::*; ;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic signed [16:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
		logic [16:0] ts, tt;
		logic err;
	} vertex_t;

	class vertex_scoreboard;
		vertex_t pending[$];
		int errors;
		logic [15:0] radius;
		logic [7:0] stacks;
		logic [7:0] sectors;

		function void reset_regs();
			radius = RADIUS_RST;
			stacks = STACKS_RST;
			sectors = SECTORS_RST;
		endfunction

		function void write_reg(logic [1:0] addr, logic [15:0] data);
			case (addr)
				REG_RADIUS: radius = data;
				REG_STACKS: stacks = data[7:0];
				REG_SECTORS: sectors = data[7:0];
				default: ;
			endcase
		endfunction

		static function longint round_shift(longint v, int k);
			return (v + (64'sd1 <<< (k - 1))) >>> k;
		endfunction

		static function longint limit(longint v, longint lim);
			if (v > lim)
				return lim;
			if (v < -lim)
				return -lim;
			return v;
		endfunction

		static function void rotate(longint ang, output longint c, output longint s);
			longint x, y, z, dx, dy;
			x = 652032874;
			y = 0;
			z = ang;
			for (int k = 0; k < TRIG_ITER_USED; k++) begin
				dx = y >>> k;
				dy = x >>> k;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(atan_q30(k));
				end else begin
					x += dx; y -= dy; z += longint'(atan_q30(k));
				end
			end
			c = x;
			s = y;
		endfunction

		function void note_input(logic [7:0] row, logic [7:0] col);
			vertex_t v;
			longint i, j, st, se, r, a, e, ce, se_s, ca, sa, xy;
			bit flip;
			i = row;
			j = col;
			st = stacks;
			se = sectors;
			r = radius;
			v = '{default: '0};
			if (st == 0 || se == 0 || i > st || j > se) begin
				v.err = 1'b1;
				pending.push_back(v);
				return;
			end
			a = (j * 64'd6746518852 + se / 2) / se;
			e = 64'd1686629713 - (i * 64'd3373259426 + st / 2) / st;
			flip = 0;
			// Fold the azimuth into the range the rotation converges on.
			if (a > 64'd1686629713 && a <= 64'd5059889139) begin
				a -= 64'd3373259426;
				flip = 1;
			end else if (a > 64'd5059889139) begin
				a -= 64'd6746518852;
			end
			rotate(e, ce, se_s);
			rotate(a, ca, sa);
			if (flip) begin
				ca = -ca;
				sa = -sa;
			end
			xy = round_shift(r * ce, 22);
			v.px = 17'(limit(round_shift(xy * ca, 38), 65535));
			v.py = 17'(limit(round_shift(xy * sa, 38), 65535));
			v.pz = 17'(limit(round_shift(r * se_s, 30), 65535));
			v.nx = 16'(limit(round_shift(ce * ca, 46), 16384));
			v.ny = 16'(limit(round_shift(ce * sa, 46), 16384));
			v.nz = 16'(limit(round_shift(se_s, 16), 16384));
			v.ts = 17'((j * 65536 + se / 2) / se);
			v.tt = 17'((i * 65536 + st / 2) / st);
			pending.push_back(v);
		endfunction

		function void check_result(vertex_t got);
			vertex_t w;
			if (pending.size() == 0) begin
				$error("unexpected output word");
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.px !== w.px) begin $error("pos_x exp %0d got %0d", w.px, got.px); errors++; end
			if (got.py !== w.py) begin $error("pos_y exp %0d got %0d", w.py, got.py); errors++; end
			if (got.pz !== w.pz) begin $error("pos_z exp %0d got %0d", w.pz, got.pz); errors++; end
			if (got.nx !== w.nx) begin $error("normal_x exp %0d got %0d", w.nx, got.nx); errors++; end
			if (got.ny !== w.ny) begin $error("normal_y exp %0d got %0d", w.ny, got.ny); errors++; end
			if (got.nz !== w.nz) begin $error("normal_z exp %0d got %0d", w.nz, got.nz); errors++; end
			if (got.ts !== w.ts) begin $error("tex_s exp %0d got %0d", w.ts, got.ts); errors++; end
			if (got.tt !== w.tt) begin $error("tex_t exp %0d got %0d", w.tt, got.tt); errors++; end
			if (got.err !== w.err) begin
				$error("index_error exp %0d got %0d", w.err, got.err);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_addr;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] stack_index;
	logic [7:0] sector_index;
	logic out_valid;
	logic out_stall;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [16:0] tex_s, tex_t;
	logic index_error;

	vertex_scoreboard sb;
	bit steady;
	int idle_cycles;

	uv_sphere_vertex_generator_top dut (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Output side: check accepted words, stall at random, watch for a hang.
	always @(posedge clk) begin
		vertex_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
					tex_s, tex_t, index_error};
				sb.check_result(got);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			out_stall <= !steady && ($urandom_range(99) < 27);
		end
	end

	task automatic write_reg(logic [1:0] addr, logic [15:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(addr, data);
	endtask

	// Waits until every word in flight has come back, then lets the pipe settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [15:0] r, logic [7:0] st, logic [7:0] se);
		drain();
		write_reg(REG_RADIUS, r);
		write_reg(REG_STACKS, {8'd0, st});
		write_reg(REG_SECTORS, {8'd0, se});
	endtask

	task automatic send_point(logic [7:0] row, logic [7:0] col);
		// Idle cycles are drawn one at a time, each with a chance of 27 in 100.
		while (!steady && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stack_index <= row;
		sector_index <= col;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(row, col);
	endtask

	task automatic random_phase(int count);
		logic [7:0] row, col;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 85) begin
				row = (sb.stacks == 0) ? 8'd0 : 8'($urandom_range(sb.stacks));
				col = (sb.sectors == 0) ? 8'd0 : 8'($urandom_range(sb.sectors));
			end else begin
				row = 8'($urandom_range(255));
				col = 8'($urandom_range(255));
			end
			send_point(row, col);
			if (n == count / 2 && $urandom_range(1))
				drain();
		end
	endtask

	initial begin
		sb = new();
		sb.reset_regs();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_addr = REG_RADIUS;
		cfg_data = '0;
		in_valid = 1'b0;
		stack_index = '0;
		sector_index = '0;
		out_stall = 1'b0;
		steady = 0;
		idle_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: poles, seam, equator and out-of-range points.
		send_point(8'd0, 8'd0);
		send_point(8'd16, 8'd32);
		send_point(8'd8, 8'd8);
		send_point(8'd4, 8'd24);
		send_point(8'd12, 8'd16);
		send_point(8'd17, 8'd0);
		send_point(8'd0, 8'd33);
		send_point(8'd255, 8'd255);
		configure(16'hFFFF, 8'd255, 8'd255);
		send_point(8'd0, 8'd0);
		send_point(8'd255, 8'd255);
		send_point(8'd128, 8'd64);
		send_point(8'd170, 8'd191);
		configure(16'd0, 8'd1, 8'd1);
		send_point(8'd0, 8'd0);
		send_point(8'd1, 8'd1);
		send_point(8'd2, 8'd0);
		configure(16'd384, 8'd0, 8'd0);
		send_point(8'd0, 8'd0);
		// An unknown register index must leave every setting alone.
		drain();
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_STACKS, 16'd2);
		write_reg(REG_SECTORS, 16'd3);
		send_point(8'd1, 8'd2);
		send_point(8'd2, 8'd3);

		steady = 1;
		random_phase(90);
		steady = 0;
		random_phase(90);
		configure(16'($urandom_range(65535)), 8'($urandom_range(255, 1)),
			8'($urandom_range(255, 1)));
		random_phase(90);
		configure(16'hFFFF, 8'd255, 8'd255);
		random_phase(90);
		configure(16'($urandom_range(2048)), 8'($urandom_range(8, 1)),
			8'($urandom_range(8, 1)));
		random_phase(90);
		configure(16'($urandom_range(65535)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		random_phase(80);

		drain();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
